// ----- rtl/pss_pkg.sv -----
package pss_pkg;

  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int TGT_W      = VALUE_BITS + 1;
  localparam int IDX_W      = 11;

  typedef enum logic [1:0] {
    REQ_PUSH_FIRST  = 2'd0,
    REQ_PUSH_SECOND = 2'd1,
    REQ_START       = 2'd2,
    REQ_UNUSED      = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_FST_RD,
    S_FST_CHK,
    S_BS_RD,
    S_BS_CMP,
    S_DONE
  } state_t;

endpackage

// ----- rtl/pss_ram.sv -----
module pss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pair_sum_search_core.sv -----
// Pair sum search core.
//
// Input channel (in_valid / in_stall) carries beats of req_type and
// length_value. A push to the first list is written as it is accepted. A
// push to the second list does an insertion sort in memory, moving each
// larger entry up one place. A start beat walks the first list in load
// order: it fetches each entry, then does a binary search through the
// second-list memory. One result beat (out_valid / out_stall) follows each
// start; pushes are accepted while that result waits, a start that finishes
// holds until the output register is free. The user must write target_sum
// via cfg_we / cfg_data only while idle; the core does not enforce this.
// Reset (rst, synchronous) empties both lists, clears the drop flag,
// target_sum and out_valid; memory contents are not cleared and are never
// used before being written.
module pair_sum_search_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pss_pkg::TGT_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                req_type,
  input  logic [31:0]               length_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pss_pkg::IDX_W-1:0] first_index,
  output logic [pss_pkg::IDX_W-1:0] second_index,
  output logic                      found,
  output logic                      overflowed
);
  import pss_pkg::*;

  state_t state, state_next;
  logic [TGT_W-1:0] target_sum;
  logic [CNT_W-1:0] first_count, first_count_next;
  logic [CNT_W-1:0] second_count, second_count_next;
  logic drop_flag, drop_flag_next;
  logic [VALUE_BITS-1:0] ins_value, ins_value_next;
  logic [ADDR_W-1:0] ins_pos, ins_pos_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [VALUE_BITS-1:0] needed, needed_next;
  logic [CNT_W-1:0] lo, lo_next, hp, hp_next;
  logic [ADDR_W-1:0] mid, mid_next;
  logic [IDX_W-1:0] hit_first, hit_first_next, hit_second, hit_second_next;
  logic hit, hit_next;
  logic out_load;

  logic f_we;
  logic [ADDR_W-1:0] f_waddr, f_raddr;
  logic [VALUE_BITS-1:0] f_wdata, f_rdata;
  logic s_we;
  logic [ADDR_W-1:0] s_waddr, s_raddr;
  logic [ADDR_W+VALUE_BITS-1:0] s_wdata, s_rdata;

  logic [VALUE_BITS-1:0] s_val;
  logic [ADDR_W-1:0] s_org;
  logic [TGT_W-1:0] diff;
  logic [CNT_W:0] mid_sum;
  logic [CNT_W-1:0] idx_inc, lo_up;
  logic in_acc;

  pss_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_first (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  pss_ram #(.WIDTH(ADDR_W + VALUE_BITS), .DEPTH(DEPTH)) u_second (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign s_val    = s_rdata[VALUE_BITS-1:0];
  assign s_org    = s_rdata[ADDR_W+VALUE_BITS-1:VALUE_BITS];
  assign diff     = target_sum - {1'b0, f_rdata};
  assign mid_sum  = {1'b0, lo} + {1'b0, hp} - {{CNT_W{1'b0}}, 1'b1};
  assign idx_inc  = idx + {{(CNT_W-1){1'b0}}, 1'b1};
  assign lo_up    = {1'b0, mid} + {{(CNT_W-1){1'b0}}, 1'b1};

  always_comb begin
    state_next        = state;
    first_count_next  = first_count;
    second_count_next = second_count;
    drop_flag_next    = drop_flag;
    ins_value_next    = ins_value;
    ins_pos_next      = ins_pos;
    idx_next          = idx;
    needed_next       = needed;
    lo_next           = lo;
    hp_next           = hp;
    mid_next          = mid;
    hit_first_next    = hit_first;
    hit_second_next   = hit_second;
    hit_next          = hit;
    out_load          = 1'b0;
    f_we    = 1'b0;
    f_waddr = first_count[ADDR_W-1:0];
    f_wdata = length_value[VALUE_BITS-1:0];
    f_raddr = idx[ADDR_W-1:0];
    s_we    = 1'b0;
    s_waddr = ins_pos;
    s_wdata = {second_count[ADDR_W-1:0], ins_value};
    s_raddr = ins_pos - {{(ADDR_W-1){1'b0}}, 1'b1};
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          priority case (req_type)
            REQ_PUSH_FIRST: begin
              if (first_count < CNT_W'(DEPTH)) begin
                f_we = 1'b1;
                first_count_next = first_count + {{(CNT_W-1){1'b0}}, 1'b1};
              end else begin
                drop_flag_next = 1'b1;
              end
            end
            REQ_PUSH_SECOND: begin
              if (second_count < CNT_W'(DEPTH)) begin
                ins_value_next = length_value[VALUE_BITS-1:0];
                ins_pos_next   = second_count[ADDR_W-1:0];
                state_next     = S_INS_RD;
              end else begin
                drop_flag_next = 1'b1;
              end
            end
            REQ_START: begin
              idx_next        = '0;
              hit_next        = 1'b0;
              hit_first_next  = '0;
              hit_second_next = '0;
              if (first_count == '0 || second_count == '0) begin
                state_next = S_DONE;
              end else begin
                state_next = S_FST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (ins_pos == '0) begin
          s_we = 1'b1;
          second_count_next = second_count + {{(CNT_W-1){1'b0}}, 1'b1};
          state_next = S_IDLE;
        end else begin
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        s_we = 1'b1;
        if (s_val > ins_value) begin
          s_wdata      = s_rdata;
          ins_pos_next = ins_pos - {{(ADDR_W-1){1'b0}}, 1'b1};
          state_next   = S_INS_RD;
        end else begin
          second_count_next = second_count + {{(CNT_W-1){1'b0}}, 1'b1};
          state_next = S_IDLE;
        end
      end
      S_FST_RD: begin
        state_next = S_FST_CHK;
      end
      S_FST_CHK: begin
        if ({1'b0, f_rdata} > target_sum || diff[TGT_W-1]) begin
          idx_next   = idx_inc;
          state_next = (idx_inc == first_count) ? S_DONE : S_FST_RD;
        end else begin
          needed_next = diff[VALUE_BITS-1:0];
          lo_next     = '0;
          hp_next     = second_count;
          state_next  = S_BS_RD;
        end
      end
      S_BS_RD: begin
        mid_next   = mid_sum[ADDR_W:1];
        s_raddr    = mid_sum[ADDR_W:1];
        state_next = S_BS_CMP;
      end
      S_BS_CMP: begin
        if (s_val == needed) begin
          hit_next        = 1'b1;
          hit_first_next  = IDX_W'(idx_inc);
          hit_second_next = IDX_W'({1'b0, s_org} + {{ADDR_W{1'b0}}, 1'b1});
          state_next      = S_DONE;
        end else begin
          if (s_val < needed) begin
            lo_next = lo_up;
          end else begin
            hp_next = {1'b0, mid};
          end
          if (lo_next < hp_next) begin
            state_next = S_BS_RD;
          end else begin
            idx_next   = idx_inc;
            state_next = (idx_inc == first_count) ? S_DONE : S_FST_RD;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load          = 1'b1;
          first_count_next  = '0;
          second_count_next = '0;
          drop_flag_next    = 1'b0;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      target_sum   <= '0;
      first_count  <= '0;
      second_count <= '0;
      drop_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      first_count  <= first_count_next;
      second_count <= second_count_next;
      drop_flag    <= drop_flag_next;
      if (cfg_we) begin
        target_sum <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ins_value  <= ins_value_next;
    ins_pos    <= ins_pos_next;
    idx        <= idx_next;
    needed     <= needed_next;
    lo         <= lo_next;
    hp         <= hp_next;
    mid        <= mid_next;
    hit_first  <= hit_first_next;
    hit_second <= hit_second_next;
    hit        <= hit_next;
    if (out_load) begin
      first_index  <= hit_first;
      second_index <= hit_second;
      found        <= hit;
      overflowed   <= drop_flag;
    end
  end

  a_first_cnt: assert property (@(posedge clk) disable iff (rst)
    first_count <= CNT_W'(DEPTH))
    else $error("first list count beyond depth");

  a_second_cnt: assert property (@(posedge clk) disable iff (rst)
    second_count <= CNT_W'(DEPTH))
    else $error("second list count beyond depth");

  a_found_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((found == (first_index != '0)) && (found == (second_index != '0))))
    else $error("result indices disagree with found");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (first_count == '0 && second_count == '0 && !drop_flag))
    else $error("lists not emptied after result");

endmodule

// ----- bench/pair_sum_search_checker.sv -----
`timescale 1ns / 1ps

module pair_sum_search_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pss_pkg::TGT_W-1:0] cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                req_type,
  input  logic [31:0]               length_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [pss_pkg::IDX_W-1:0] first_index,
  input  logic [pss_pkg::IDX_W-1:0] second_index,
  input  logic                      found,
  input  logic                      overflowed,
  output int                        errors,
  output int                        pending,
  output int                        matches_seen
);
  import pss_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] fi;
    logic [IDX_W-1:0] si;
    logic             hit;
    logic             ovf;
  } pair_answer_t;

  pair_answer_t            answers_q[$];
  logic [TGT_W-1:0]        target;
  logic [VALUE_BITS-1:0]   first_len [DEPTH];
  logic [VALUE_BITS-1:0]   second_len [DEPTH];
  int                      second_pos [DEPTH];
  int                      n_first;
  int                      n_second;
  logic                    dropped;
  int                      err_cnt;
  int                      hit_cnt;

  function automatic int probe_second(logic [TGT_W-1:0] want);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n_second - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if ({1'b0, second_len[mid]} == want) return mid;
      if ({1'b0, second_len[mid]} < want) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic pair_answer_t find_pair();
    pair_answer_t ans;
    logic [TGT_W-1:0] want;
    int slot;
    ans = '0;
    for (int i = 0; i < n_first; i++) begin
      if ({1'b0, first_len[i]} > target) continue;
      want = target - {1'b0, first_len[i]};
      if (want[TGT_W-1]) continue;
      slot = probe_second(want);
      if (slot >= 0) begin
        ans.fi = IDX_W'(i + 1);
        ans.si = IDX_W'(second_pos[slot] + 1);
        ans.hit = 1'b1;
        break;
      end
    end
    ans.ovf = dropped;
    return ans;
  endfunction

  task automatic insert_second(logic [VALUE_BITS-1:0] v);
    int p;
    p = n_second;
    while (p > 0 && second_len[p-1] > v) begin
      second_len[p] = second_len[p-1];
      second_pos[p] = second_pos[p-1];
      p--;
    end
    second_len[p] = v;
    second_pos[p] = n_second;
    n_second++;
  endtask

  always @(posedge clk) begin
    pair_answer_t want_ans;
    if (rst) begin
      target = '0;
      n_first = 0;
      n_second = 0;
      dropped = 1'b0;
      answers_q.delete();
    end else begin
      if (cfg_we) target = cfg_data;
      if (in_valid && !in_stall) begin
        case (req_t'(req_type))
          REQ_PUSH_FIRST: begin
            if (n_first < DEPTH) begin
              first_len[n_first] = length_value;
              n_first++;
            end else dropped = 1'b1;
          end
          REQ_PUSH_SECOND: begin
            if (n_second < DEPTH) insert_second(length_value);
            else dropped = 1'b1;
          end
          REQ_START: begin
            answers_q.push_back(find_pair());
            n_first = 0;
            n_second = 0;
            dropped = 1'b0;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (answers_q.size() == 0) begin
          $error("result beat with nothing expected");
          err_cnt++;
        end else begin
          want_ans = answers_q.pop_front();
          if (found) hit_cnt++;
          if (first_index !== want_ans.fi) begin
            $error("first_index expected %0d got %0d", want_ans.fi, first_index);
            err_cnt++;
          end
          if (second_index !== want_ans.si) begin
            $error("second_index expected %0d got %0d", want_ans.si, second_index);
            err_cnt++;
          end
          if (found !== want_ans.hit) begin
            $error("found expected %0d got %0d", want_ans.hit, found);
            err_cnt++;
          end
          if (overflowed !== want_ans.ovf) begin
            $error("overflowed expected %0d got %0d", want_ans.ovf, overflowed);
            err_cnt++;
          end
        end
      end
    end
    errors <= err_cnt;
    pending <= answers_q.size();
    matches_seen <= hit_cnt;
  end

endmodule

// ----- bench/tb_pair_sum_search_core.sv -----
`timescale 1ns / 1ps

module tb_pair_sum_search_core;
  import pss_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int DRAIN = 2200;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [TGT_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       req_type = REQ_PUSH_FIRST;
  logic [31:0]      length_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] first_index;
  logic [IDX_W-1:0] second_index;
  logic             found;
  logic             overflowed;

  int               errors;
  int               pending;
  int               matches_seen;
  int               send_idle_pct = 36;
  int               recv_stall_pct = 67;
  bit               hold_req = 1'b0;
  bit               hold_taken = 1'b0;
  int               hold_left = 0;
  int               cycles = 0;
  int               beats_sent = 0;
  int               searches = 0;
  logic [TGT_W-1:0] cur_target = '0;

  always #10 clk = ~clk;

  pair_sum_search_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .length_value(length_value), .out_valid(out_valid), .out_stall(out_stall),
    .first_index(first_index), .second_index(second_index), .found(found),
    .overflowed(overflowed)
  );

  pair_sum_search_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .length_value(length_value), .out_valid(out_valid), .out_stall(out_stall),
    .first_index(first_index), .second_index(second_index), .found(found),
    .overflowed(overflowed), .errors(errors), .pending(pending),
    .matches_seen(matches_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = 3000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send(req_t kind, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    length_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (kind == REQ_START) searches++;
  endtask

  task automatic set_target(logic [TGT_W-1:0] t);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= t;
    cur_target = t;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_len(int style);
    case (style)
      0: return 32'($urandom_range(15));
      1: return $urandom();
      2: return (cur_target > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF
                : 32'($urandom_range(32'(cur_target)));
      default: return 32'hFFFF_FFFF - 32'($urandom_range(3));
    endcase
  endfunction

  task automatic run_session(int n1, int n2, bit plant);
    logic [31:0] a_list[$];
    logic [31:0] b_list[$];
    logic [TGT_W-1:0] diff;
    int style;
    style = $urandom_range(3);
    repeat (n1) a_list.push_back(pick_len(style));
    repeat (n2) b_list.push_back(pick_len($urandom_range(3)));
    if (plant && n1 > 0 && n2 > 0) begin
      a_list[$urandom_range(n1 - 1)] = pick_len(2);
      diff = cur_target - {1'b0, a_list[0]};
      if ({1'b0, a_list[0]} <= cur_target && !diff[TGT_W-1])
        b_list[$urandom_range(n2 - 1)] = diff[31:0];
    end
    while (a_list.size() + b_list.size() > 0) begin
      if ($urandom_range(19) == 0) send(REQ_UNUSED, $urandom());
      if (b_list.size() == 0 || (a_list.size() > 0 && $urandom_range(1)))
        send(REQ_PUSH_FIRST, a_list.pop_front());
      else
        send(REQ_PUSH_SECOND, b_list.pop_front());
    end
    send(REQ_START, $urandom());
  endtask

  initial begin
    logic [TGT_W-1:0] targets[7];
    targets = '{33'd10, 33'h1_FFFF_FFFF, 33'h0_FFFF_FFFF, 33'd0, 33'h1_0000_0005,
                33'd0, 33'd100};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(REQ_START, 32'd0);
    send(REQ_PUSH_FIRST, 32'd0);
    send(REQ_START, 32'd0);
    send(REQ_PUSH_FIRST, 32'd0);
    send(REQ_PUSH_SECOND, 32'd0);
    send(REQ_UNUSED, 32'hFFFF_FFFF);
    send(REQ_START, 32'hFFFF_FFFF);
    set_target(33'd10);
    send(REQ_PUSH_FIRST, 32'd11);
    send(REQ_PUSH_FIRST, 32'd4);
    send(REQ_PUSH_FIRST, 32'd3);
    send(REQ_PUSH_SECOND, 32'd7);
    send(REQ_PUSH_SECOND, 32'd6);
    send(REQ_PUSH_SECOND, 32'd6);
    send(REQ_PUSH_SECOND, 32'hFFFF_FFFF);
    send(REQ_START, 32'd0);
    set_target(33'h1_FFFF_FFFF);
    send(REQ_PUSH_FIRST, 32'd1);
    send(REQ_PUSH_FIRST, 32'hFFFF_FFFF);
    send(REQ_PUSH_SECOND, 32'hFFFF_FFFF);
    send(REQ_PUSH_SECOND, 32'hFFFF_FFFE);
    send(REQ_START, 32'd0);
    set_target(33'h0_FFFF_FFFF);
    send(REQ_PUSH_FIRST, 32'd0);
    send(REQ_PUSH_SECOND, 32'hFFFF_FFFF);
    send(REQ_START, 32'd0);

    for (int s = 0; s < 28; s++) begin
      if (s == 9) begin
        send_idle_pct = 67;
        recv_stall_pct = 36;
      end
      if (s == 18) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (s == 20) hold_req = 1'b1;
      if (s % 4 == 0) begin
        if (s / 4 == 5) set_target({1'b0, $urandom()});
        else set_target(targets[s / 4]);
      end
      if ($urandom_range(9) == 0)
        run_session($urandom_range(1), $urandom_range(1), $urandom_range(1) != 0);
      else
        run_session($urandom_range(8), $urandom_range(8), $urandom_range(3) != 0);
    end

    set_target(33'd2000);
    send(REQ_PUSH_FIRST, 32'd5000);
    send(REQ_PUSH_FIRST, 32'd1500);
    for (int i = 0; i < DEPTH + 3; i++) send(REQ_PUSH_SECOND, 32'(i));
    send(REQ_START, 32'd0);
    send(REQ_PUSH_SECOND, 32'd1);
    send(REQ_PUSH_FIRST, 32'd1999);
    send(REQ_START, 32'd0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("%0d input beats sent, %0d searches run, %0d found a pair", beats_sent,
             searches, matches_seen);
    $display("targets covered zero, small, 32-bit max, 33-bit max; second list overflowed");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pss_pkg.sv
rtl/pss_ram.sv
rtl/pair_sum_search_core.sv
bench/pair_sum_search_checker.sv
bench/tb_pair_sum_search_core.sv
